// ===== rtl/core/wosc_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the waveform oscillator.
// Used by every file of the block; depends on nothing else.
package wosc_pkg;

   localparam int TABLE_ADDR_BITS = 10;
   localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
   localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;
   localparam int ENTRY_BITS      = 7;
   localparam int AMP_BITS        = 7;
   localparam int WAVE_BITS       = 2;
   localparam int SAMPLE_BITS     = 8;
   localparam int SAMPLE_MID      = 1 << (SAMPLE_BITS - 1);
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
   localparam int WORD_BITS       = 32;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 7;

   // triangle works on the top phase bits in Q14
   localparam int TOP_BITS        = 16;
   localparam int TRI_FRAC        = 14;
   localparam int TRI_QUARTER     = 1 << TRI_FRAC;
   localparam int TRI_HALF        = 2 << TRI_FRAC;
   localparam int TRI_THREE       = 3 << TRI_FRAC;
   localparam int TRI_FULL        = 4 << TRI_FRAC;
   localparam int TRI_ROUND       = 1 << (TRI_FRAC - 1);
   localparam int MAG_BITS        = TRI_FRAC + 1;
   localparam int PROD_BITS       = AMP_BITS + MAG_BITS;

   // round(n / 127) through a reciprocal, exact for every n below 2^14
   localparam int SINE_DEN        = 127;
   localparam int SINE_ROUND      = SINE_DEN / 2;
   localparam int SINE_NUM_BITS   = 2 * ENTRY_BITS + 1;
   localparam int SINE_SHIFT      = 21;
   localparam int SINE_RECIP      = ((1 << SINE_SHIFT) + SINE_DEN - 1) / SINE_DEN;
   localparam int SINE_PROD_BITS  = SINE_NUM_BITS + SINE_SHIFT - ENTRY_BITS + 1;
   localparam int SQUARE_LIMIT    = 64;

   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2
   } wave_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WAVEFORM  = 1'b0,
      CSR_AMPLITUDE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SCALE_SINE     = 2'd0,
      SCALE_TRIANGLE = 2'd1,
      SCALE_DIRECT   = 2'd2
   } scale_type;

   typedef struct packed {
      logic                valid;
      logic [TOP_BITS-1:0] phase_top;
      logic                tone_end;
   } stage1_type;

   typedef struct packed {
      logic                 valid;
      scale_type            scale;
      logic                 negative;
      logic [PROD_BITS-1:0] product;
      logic                 tone_end;
   } stage2_type;

   typedef logic [QUARTER_SIZE-1:0][ENTRY_BITS-1:0] quarter_table_type;

   // sin(x) for x in Q30 over the first quadrant, Taylor series to x^13
   function automatic longint sin_q30(longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint          s;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      // each step divides by (2n)(2n+1) and flips the sign
      term = ((term * x2) >> 30) / 64'd6;
      s    = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      s    = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      s    = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      s    = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      s    = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      s    = s + longint'(term);
      if (s < 0) begin
         s = 0;
      end
      return s;
   endfunction

   // magnitude of the table entry at first-quadrant index idx
   function automatic logic [ENTRY_BITS-1:0] quarter_entry(int idx);
      longint unsigned ui;
      longint unsigned x;
      longint          v;
      ui = longint'(idx);
      x  = (ui * TWO_PI_Q30) >> TABLE_ADDR_BITS;
      v  = (64'sd127 * sin_q30(x) + 64'sd536870912) >>> 30;
      if (v > 127) begin
         v = 127;
      end
      return ENTRY_BITS'(v);
   endfunction

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type t;
      for (int i = 0; i < QUARTER_SIZE; i++) begin
         t[i] = quarter_entry(i);
      end
      return t;
   endfunction

   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();
   localparam logic [ENTRY_BITS-1:0] PEAK_ENTRY = quarter_entry(QUARTER_SIZE);

endpackage

// ===== rtl/core/wosc_req_if.sv =====
// Tick request channel of the waveform oscillator: valid/ready plus tick fields.
// Depends on wosc_pkg for field widths.
interface wosc_req_if;
   logic                           valid;
   logic                           ready;
   logic [wosc_pkg::WORD_BITS-1:0] tune_word;
   logic                           restart;
   logic [wosc_pkg::WORD_BITS-1:0] start_phase;
   logic                           tone_end;

   modport source (output valid, output tune_word, output restart, output start_phase,
                   output tone_end, input ready);
   modport sink   (input valid, input tune_word, input restart, input start_phase,
                   input tone_end, output ready);
endinterface

// ===== rtl/core/wosc_rsp_if.sv =====
// Sample response channel of the waveform oscillator: valid/ready plus sample fields.
// Depends on wosc_pkg for field widths.
interface wosc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [wosc_pkg::SAMPLE_BITS-1:0] sample;
   logic                             end_of_tone;

   modport source (output valid, output sample, output end_of_tone, input ready);
   modport sink   (input valid, input sample, input end_of_tone, output ready);
endinterface

// ===== rtl/core/wosc_phase.sv =====
// Phase accumulator stage: picks the tick phase, advances the accumulator, registers it.
// Depends on wosc_pkg and wosc_req_if.
module wosc_phase #(
   parameter int PHASE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   wosc_req_if.sink             req_chan,
   input  logic                 s1_ready,
   output wosc_pkg::stage1_type s1
);

   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [PHASE_BITS-1:0] phase;
   wosc_pkg::stage1_type  s1_ff, s1_in;
   logic                  take;

   assign req_chan.ready = !s1_ff.valid || s1_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign s1             = s1_ff;

   always_comb begin
      phase  = req_chan.restart ? PHASE_BITS'(req_chan.start_phase) : acc_ff;
      acc_in = acc_ff;
      s1_in  = s1_ff;
      if (take) begin
         // a tone end sends the next tone back to phase zero
         acc_in          = req_chan.tone_end ? '0 : phase + PHASE_BITS'(req_chan.tune_word);
         s1_in.valid     = 1'b1;
         s1_in.phase_top = phase[PHASE_BITS-1 -: wosc_pkg::TOP_BITS];
         s1_in.tone_end  = req_chan.tone_end;
      end else if (s1_ready) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         s1_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         s1_ff  <= s1_in;
      end
   end

endmodule

// ===== rtl/core/wosc_shape.sv =====
// Waveform stage: sine table lookup or triangle fold, then amplitude product.
// Depends on wosc_pkg.
module wosc_shape (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [wosc_pkg::WAVE_BITS-1:0]      waveform,
   input  logic [wosc_pkg::AMP_BITS-1:0]       amplitude,
   input  wosc_pkg::stage1_type                s1,
   output logic                                s1_ready,
   input  logic                                s2_ready,
   output wosc_pkg::stage2_type                s2
);

   localparam int QB = wosc_pkg::QUARTER_BITS;
   localparam int EB = wosc_pkg::ENTRY_BITS;
   localparam int MB = wosc_pkg::MAG_BITS;
   localparam int PB = wosc_pkg::PROD_BITS;
   localparam int TB = wosc_pkg::TOP_BITS;

   wosc_pkg::stage2_type s2_ff, s2_in;
   logic [wosc_pkg::TABLE_ADDR_BITS-1:0] addr;
   logic [QB-1:0]  idx, mirror;
   logic [EB-1:0]  sine_mag;
   logic           sine_neg;
   logic [TB:0]    q;
   logic [MB-1:0]  tri_mag;
   logic           tri_neg;
   logic [MB-1:0]  factor;
   logic           take;

   assign s1_ready = !s2_ff.valid || s2_ready;
   assign take     = s1.valid && s1_ready;
   assign s2       = s2_ff;

   // quarter-wave table: mirror in odd quadrants, negate in the second half of the period
   always_comb begin
      addr     = s1.phase_top[TB-1 -: wosc_pkg::TABLE_ADDR_BITS];
      idx      = addr[QB-1:0];
      mirror   = ~idx + 1'b1;
      sine_neg = addr[QB+1];
      if (!addr[QB]) begin
         sine_mag = wosc_pkg::QUARTER_TABLE[idx];
      end else if (idx == '0) begin
         sine_mag = wosc_pkg::PEAK_ENTRY;
      end else begin
         sine_mag = wosc_pkg::QUARTER_TABLE[mirror];
      end
   end

   // fold the phase into a Q14 triangle, kept as sign and magnitude
   always_comb begin
      q = {1'b0, s1.phase_top};
      priority if (q < (TB+1)'(wosc_pkg::TRI_QUARTER)) begin
         tri_mag = MB'(q);
         tri_neg = 1'b0;
      end else if (q <= (TB+1)'(wosc_pkg::TRI_HALF)) begin
         tri_mag = MB'((TB+1)'(wosc_pkg::TRI_HALF) - q);
         tri_neg = 1'b0;
      end else if (q < (TB+1)'(wosc_pkg::TRI_THREE)) begin
         tri_mag = MB'(q - (TB+1)'(wosc_pkg::TRI_HALF));
         tri_neg = 1'b1;
      end else begin
         tri_mag = MB'((TB+1)'(wosc_pkg::TRI_FULL) - q);
         tri_neg = 1'b1;
      end
   end

   always_comb begin
      s2_in  = s2_ff;
      factor = MB'(sine_mag);
      if (waveform == wosc_pkg::WAVE_TRIANGLE) begin
         factor = tri_mag;
      end
      if (take) begin
         s2_in.valid    = 1'b1;
         s2_in.tone_end = s1.tone_end;
         unique case (waveform)
            wosc_pkg::WAVE_SINE: begin
               s2_in.scale    = wosc_pkg::SCALE_SINE;
               s2_in.negative = sine_neg;
               s2_in.product  = PB'(amplitude) * PB'(factor);
            end
            wosc_pkg::WAVE_SQUARE: begin
               // high only where the sine is above one half
               s2_in.scale    = wosc_pkg::SCALE_DIRECT;
               s2_in.negative = sine_neg || (sine_mag < EB'(wosc_pkg::SQUARE_LIMIT));
               s2_in.product  = PB'(amplitude);
            end
            wosc_pkg::WAVE_TRIANGLE: begin
               s2_in.scale    = wosc_pkg::SCALE_TRIANGLE;
               s2_in.negative = tri_neg;
               s2_in.product  = PB'(amplitude) * PB'(factor);
            end
            default: begin
               // unused code: silence at midscale
               s2_in.scale    = wosc_pkg::SCALE_DIRECT;
               s2_in.negative = 1'b0;
               s2_in.product  = '0;
            end
         endcase
      end else if (s2_ready) begin
         s2_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

endmodule

// ===== rtl/core/wosc_scale.sv =====
// Output stage: rounds the amplitude product, offsets to midscale, saturates, registers.
// Depends on wosc_pkg and wosc_rsp_if.
module wosc_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  wosc_pkg::stage2_type s2,
   output logic                 s2_ready,
   wosc_rsp_if.source           rsp_chan
);

   localparam int EB = wosc_pkg::ENTRY_BITS;
   localparam int SB = wosc_pkg::SAMPLE_BITS;
   localparam int NB = wosc_pkg::SINE_NUM_BITS;
   localparam int RB = wosc_pkg::SINE_PROD_BITS;
   localparam int PB = wosc_pkg::PROD_BITS;
   localparam int WB = SB + 2;

   logic          valid_ff, valid_in;
   logic [SB-1:0] sample_ff, sample_in;
   logic          end_ff, end_in;
   logic [NB-1:0] sine_num;
   logic [RB-1:0] sine_quot;
   logic [PB:0]   tri_sum;
   logic [EB-1:0] dev;
   logic signed [WB-1:0] level;
   logic          take;

   assign s2_ready             = !valid_ff || rsp_chan.ready;
   assign take                 = s2.valid && s2_ready;
   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.sample      = sample_ff;
   assign rsp_chan.end_of_tone = end_ff;

   always_comb begin
      sine_num  = NB'(s2.product) + NB'(wosc_pkg::SINE_ROUND);
      sine_quot = (RB'(sine_num) * RB'(wosc_pkg::SINE_RECIP)) >> wosc_pkg::SINE_SHIFT;
      tri_sum   = (PB+1)'(s2.product) + (PB+1)'(wosc_pkg::TRI_ROUND);
      unique case (s2.scale)
         wosc_pkg::SCALE_SINE:     dev = sine_quot[EB-1:0];
         wosc_pkg::SCALE_TRIANGLE: dev = tri_sum[wosc_pkg::TRI_FRAC +: EB];
         default:                  dev = s2.product[EB-1:0];
      endcase
      level = s2.negative ? WB'(wosc_pkg::SAMPLE_MID) - WB'(dev)
                          : WB'(wosc_pkg::SAMPLE_MID) + WB'(dev);
      priority if (level < 0) begin
         sample_in = '0;
      end else if (level > WB'(wosc_pkg::SAMPLE_MAX)) begin
         sample_in = SB'(wosc_pkg::SAMPLE_MAX);
      end else begin
         sample_in = level[SB-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      end_in   = end_ff;
      if (take) begin
         valid_in = 1'b1;
         end_in   = s2.tone_end;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= sample_in;
      end
      end_ff <= end_in;
   end

endmodule

// ===== rtl/core/waveform_oscillator.sv =====
// Direct digital synthesis oscillator: sine, square and triangle from a phase accumulator.
// Depends on wosc_pkg, wosc_req_if, wosc_rsp_if, wosc_phase, wosc_shape, wosc_scale.
//
// Usage:
//   req_chan carries one sample tick per transfer: tune_word (phase step), restart with
//   start_phase (use that phase for this tick), and tone_end (last tick of a tone; the
//   accumulator returns to zero afterward). rsp_chan returns one sample per tick, in
//   order, with end_of_tone copied from the tick.
//   csr_write_enable/csr_index/csr_write_data set waveform (index 0) and amplitude
//   (index 1); write them only while no tick is in flight.
//   Throughput: one tick per cycle while rsp_chan is ready; three register stages (phase
//   accumulator, table lookup and amplitude product, rounding and output) each hold one
//   tick. Reset clears the accumulator and the valid flag of every stage, and sets sine
//   at amplitude 127. When the receiver stalls, the output holds its sample and the
//   stages behind it keep filling; req_chan.ready drops only once all three stages are
//   full.
module waveform_oscillator #(
   parameter int PHASE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   wosc_req_if.sink                                req_chan,
   wosc_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [wosc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wosc_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   logic [wosc_pkg::WAVE_BITS-1:0] waveform_ff, waveform_in;
   logic [wosc_pkg::AMP_BITS-1:0]  amplitude_ff, amplitude_in;
   wosc_pkg::stage1_type           s1;
   wosc_pkg::stage2_type           s2;
   logic                           s1_ready;
   logic                           s2_ready;

   always_comb begin
      waveform_in  = waveform_ff;
      amplitude_in = amplitude_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wosc_pkg::CSR_WAVEFORM:
               waveform_in = csr_write_data[wosc_pkg::WAVE_BITS-1:0];
            wosc_pkg::CSR_AMPLITUDE:
               amplitude_in = csr_write_data[wosc_pkg::AMP_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff  <= wosc_pkg::WAVE_SINE;
         amplitude_ff <= '1;
      end else begin
         waveform_ff  <= waveform_in;
         amplitude_ff <= amplitude_in;
      end
   end

   wosc_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .s1_ready (s1_ready),
      .s1       (s1)
   );

   wosc_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .waveform  (waveform_ff),
      .amplitude (amplitude_ff),
      .s1        (s1),
      .s1_ready  (s1_ready),
      .s2_ready  (s2_ready),
      .s2        (s2)
   );

   wosc_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .s2       (s2),
      .s2_ready (s2_ready),
      .rsp_chan (rsp_chan)
   );

endmodule
